// ----- rtl/core/tdpt_pkg.sv -----
package tdpt_pkg;

	// Sequencer states of the trial-division engine, one-hot coded.
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CHECK = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_NEXT  = 5'b01000,
		ST_DONE  = 5'b10000
	} tdpt_state_t;

endpackage

// ----- rtl/core/trial_division_prime_test.sv -----
// Each word is tried against the divisors 2, 3, ... while the divisor squared does not exceed it,
// at most floor(sqrt(candidate)) - 1 divisors (254 for 16 bits); each divisor passes through CHECK,
// a run of DIV steps, one per dividend bit, and NEXT. One word at a time: the next word is taken in
// the cycle after the result has been taken. The cost per divisor is set by the shared restoring
// divider, one quotient bit per cycle.
// Reset: arst_n clears the sequencer and the result valid flag asynchronously.
module trial_division_prime_test #(
	parameter int VALUE_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [VALUE_WIDTH-1:0] candidate,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [VALUE_WIDTH-1:0] tested_value,
	output logic                   is_prime
);
	import tdpt_pkg::*;

	localparam int CntW = (VALUE_WIDTH > 2) ? $clog2(VALUE_WIDTH) : 1;
	localparam logic [CntW-1:0] LastBit = CntW'(VALUE_WIDTH - 1);

	tdpt_state_t              state_q;
	logic [VALUE_WIDTH-1:0]   n_q;
	logic [VALUE_WIDTH-1:0]   d_q;
	logic [VALUE_WIDTH:0]     sq_q;
	logic [VALUE_WIDTH:0]     rem_q;
	logic [VALUE_WIDTH-1:0]   sh_q;
	logic [CntW-1:0]          cnt_q;
	logic                     prime_q;

	logic [VALUE_WIDTH:0]     rem_shift;
	logic [VALUE_WIDTH+1:0]   diff;
	logic [VALUE_WIDTH:0]     rem_next;
	logic [VALUE_WIDTH:0]     sq_next;

	// Shared restoring divider step: shift in one dividend bit, subtract if it fits.
	always_comb begin
		rem_shift = {rem_q[VALUE_WIDTH-1:0], sh_q[VALUE_WIDTH-1]};
		diff      = {1'b0, rem_shift} - {2'b00, d_q};
		rem_next  = diff[VALUE_WIDTH+1] ? rem_shift : diff[VALUE_WIDTH:0];
		// (d + 1)^2 = d^2 + 2d + 1, so the bound tracks the divisor without a multiplier.
		sq_next   = sq_q + {d_q, 1'b1};
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = (state_q == ST_DONE);
	assign tested_value = n_q;
	assign is_prime     = prime_q;

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (n_q < VALUE_WIDTH'(2) || sq_q > {1'b0, n_q}) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LastBit) state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					if (rem_q == '0) state_q <= ST_DONE;
					else state_q <= ST_CHECK;
				end
				ST_DONE: begin
					if (out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers: candidate, divisor, its square and the running remainder.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					n_q     <= candidate;
					d_q     <= VALUE_WIDTH'(2);
					sq_q    <= (VALUE_WIDTH+1)'(4);
					prime_q <= 1'b0;
				end
			end
			ST_CHECK: begin
				if (n_q < VALUE_WIDTH'(2)) begin
					prime_q <= 1'b0;
				end else if (sq_q > {1'b0, n_q}) begin
					prime_q <= 1'b1;
				end else begin
					rem_q <= '0;
					sh_q  <= n_q;
				end
			end
			ST_DIV: begin
				rem_q <= rem_next;
				sh_q  <= {sh_q[VALUE_WIDTH-2:0], 1'b0};
			end
			ST_NEXT: begin
				if (rem_q == '0) begin
					prime_q <= 1'b0;
				end else begin
					d_q  <= d_q + 1'b1;
					sq_q <= sq_next;
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Input and output sides are never open together.
	a_excl_handshake: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("in_ready and out_valid high together");

	// An accepted word closes the input until its result has been taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input reopened straight after accepting a word");

	// A word reported prime is at least two.
	a_prime_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_prime) |-> (tested_value >= VALUE_WIDTH'(2)))
		else $error("zero or one reported prime");

	// A remainder of zero never leads back to another trial divisor.
	a_stop_on_factor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NEXT && rem_q == '0) |=> (state_q == ST_DONE && !is_prime))
		else $error("search went on past an exact divisor");

endmodule
